// ===== hdl/bm25ps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the BM25L posting scorer: payload structs, register indexes,
// reset values and fixed datapath widths. Depends on nothing.
package bm25ps_pkg;

	// Defaults for the top-level parameters.
	localparam int DocCountDef   = 65536;
	localparam int LengthBitsDef = 32;

	// Configuration register indexes.
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] CFG_K1       = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_B        = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_DELTA    = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MEAN     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_PRESCALE = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_POSTSCL  = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_IDF      = 3'd6;
	localparam int CfgDataW = 32;

	// Reset values of the registers.
	localparam logic [23:0] K1Rst       = 24'd78643;
	localparam logic [16:0] BRst        = 17'd19661;
	localparam logic [23:0] DeltaRst    = 24'd32768;
	localparam logic [31:0] MeanRst     = 32'd1;
	localparam logic [23:0] PrescaleRst = 24'd65536;
	localparam logic [23:0] PostsclRst  = 24'd65536;
	localparam logic [23:0] IdfRst      = 24'd0;

	// Operation codes of an input item.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SCORE = 1'b1;

	// Fixed-point constants.
	localparam logic [16:0] OneQ16    = 17'd65536;
	localparam logic [47:0] CPrimeCap = 48'hFFFF_FFFF_FFFF;

	// Shared divider widths.
	localparam int DivNumW = 88;
	localparam int DivDenW = 50;
	localparam int DivCntW = $clog2(DivNumW);

	typedef struct packed {
		logic        op;
		logic        restart;
		logic [16:0] docid_gap;
		logic [15:0] impact_value;
		logic [15:0] table_index;
		logic [31:0] table_length;
	} in_item_t;

	typedef struct packed {
		logic [15:0] doc_number;
		logic [31:0] score;
	} out_item_t;

endpackage

// ===== hdl/bm25l_posting_scorer_core.sv =====
`timescale 1ns / 1ps
// BM25L posting scorer top level: sequencer, multipliers, registers.
// Depends on bm25ps_pkg, bm25ps_len_ram and bm25ps_divider.
//
//  Channel | Signals                        | Direction | Moves
//  in      | in_valid, in_ready, in_data    | into core | load or score item
//  out     | out_valid, out_ready, out_data | out       | document number, score
//  cfg     | cfg_we, cfg_index, cfg_data    | into core | register write
//
// A load item, or a score item that gives no result, stays in IDLE. A scored
// item runs the length table read, multiplies, sums and two passes of the
// shared one-bit-a-cycle divider (c', then the saturation term), each ending
// in a done cycle; a zero divisor skips its pass. Reset clears control and
// sets the configuration registers to reset values; datapath registers and
// the length table are not reset. The result register lets the next item
// enter while a score waits on out_ready; only a second score then stalls.
module bm25l_posting_scorer_core #(
	parameter int DOC_COUNT   = bm25ps_pkg::DocCountDef,
	parameter int LENGTH_BITS = bm25ps_pkg::LengthBitsDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  bm25ps_pkg::in_item_t               in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output bm25ps_pkg::out_item_t              out_data,
	input  logic                               cfg_we,
	input  logic [bm25ps_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [bm25ps_pkg::CfgDataW-1:0]    cfg_data
);
	import bm25ps_pkg::*;

	localparam int TableDepth = (DOC_COUNT < 65536) ? DOC_COUNT : 65536;
	localparam int AddrW      = $clog2(TableDepth);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_MUL1  = 12'b0000_0000_0010,
		ST_MUL2  = 12'b0000_0000_0100,
		ST_DIV1S = 12'b0000_0000_1000,
		ST_DIV1  = 12'b0000_0001_0000,
		ST_XS    = 12'b0000_0010_0000,
		ST_X2    = 12'b0000_0100_0000,
		ST_DIV2S = 12'b0000_1000_0000,
		ST_DIV2  = 12'b0001_0000_0000,
		ST_SC1   = 12'b0010_0000_0000,
		ST_SC2   = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [23:0] k1_q, delta_q, prescale_q, postscale_q, idf_q;
	logic [16:0] b_q;
	logic [31:0] mean_q;

	// Running document number and output register.
	logic [16:0] run_q;
	logic        out_valid_q;
	out_item_t   out_q;

	// Datapath registers.
	logic [15:0] doc_q;
	logic [39:0] tf_q;
	logic [51:0] pa_q, pb_q;
	logic [48:0] pd1_q, pd2_q;
	logic [49:0] d_q;
	logic [47:0] cp_q;
	logic [48:0] x_q;
	logic [49:0] den2_q;
	logic [49:0] pxl_q;
	logic [48:0] pxh_q;
	logic [24:0] fp_q;
	logic [32:0] s1_q;
	logic [31:0] score_q;

	// Combinational helpers.
	logic        in_acc;
	logic        load_acc, score_acc;
	logic [16:0] run_new;
	logic        run_ok;
	logic [39:0] tf_new;
	logic [16:0] b_eff, one_minus_b;
	logic [31:0] m_eff;
	logic [31:0] len;
	logic [LENGTH_BITS-1:0] rd_data;
	logic        tidx_ok;
	logic [24:0] k1p1;
	logic [71:0] num1_sum;
	logic [73:0] num2_sum;
	logic        div_start;
	logic [DivNumW-1:0] div_num;
	logic [DivDenW-1:0] div_den;
	logic        div_done;
	logic [DivNumW-1:0] div_quo;
	logic [48:0] x_new;
	logic [48:0] sc1_prod;
	logic [56:0] sc2_prod;
	logic        out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && (in_data.op == OP_LOAD);
	assign score_acc = in_acc && (in_data.op == OP_SCORE);
	assign out_free  = !out_valid_q || out_ready;

	// Document number step and term frequency of an arriving score item.
	always_comb begin
		run_new = (in_data.restart ? '1 : run_q) + in_data.docid_gap;
		run_ok  = (18'(run_new) < 18'(TableDepth)) && (run_new <= 17'd65535);
		tf_new  = 40'(in_data.impact_value) * 40'(prescale_q);
		tidx_ok = 17'(in_data.table_index) < 17'(TableDepth);
	end

	// Effective constants: b clamped to one, mean of zero read as one.
	always_comb begin
		b_eff       = (b_q > OneQ16) ? OneQ16 : b_q;
		one_minus_b = OneQ16 - b_eff;
		m_eff       = (mean_q == '0) ? 32'd1 : mean_q;
		len         = 32'(rd_data);
		k1p1        = 25'(k1_q) + 25'(OneQ16);
		num1_sum    = {pb_q, 20'b0} + 72'(pa_q);
		num2_sum    = {pxh_q, 25'b0} + 74'(pxl_q);
		x_new       = 49'(cp_q) + 49'(delta_q);
		sc1_prod    = 49'(fp_q) * 49'(idf_q);
		sc2_prod    = 57'(s1_q) * 57'(postscale_q);
	end

	bm25ps_len_ram #(
		.Depth (TableDepth),
		.Width (LENGTH_BITS)
	) u_len_ram (
		.clk     (clk),
		.wr_en   (load_acc && tidx_ok),
		.wr_addr (in_data.table_index[AddrW-1:0]),
		.wr_data (in_data.table_length[LENGTH_BITS-1:0]),
		.rd_en   (score_acc),
		.rd_addr (run_new[AddrW-1:0]),
		.rd_data (rd_data)
	);

	// Divider start and operand selection for the two divisions.
	always_comb begin
		div_start = 1'b0;
		div_num   = {num1_sum, 16'b0};
		div_den   = d_q;
		if (state_q == ST_DIV1S) begin
			div_start = (d_q != '0);
		end else if (state_q == ST_DIV2S) begin
			div_start = (den2_q != '0);
			div_num   = DivNumW'(num2_sum);
			div_den   = den2_q;
		end
	end

	bm25ps_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q        <= K1Rst;
			b_q         <= BRst;
			delta_q     <= DeltaRst;
			mean_q      <= MeanRst;
			prescale_q  <= PrescaleRst;
			postscale_q <= PostsclRst;
			idf_q       <= IdfRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_K1:       k1_q        <= cfg_data[23:0];
				CFG_B:        b_q         <= cfg_data[16:0];
				CFG_DELTA:    delta_q     <= cfg_data[23:0];
				CFG_MEAN:     mean_q      <= cfg_data;
				CFG_PRESCALE: prescale_q  <= cfg_data[23:0];
				CFG_POSTSCL:  postscale_q <= cfg_data[23:0];
				CFG_IDF:      idf_q       <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Sequencer, running document number and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= '1;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the register; otherwise a taken one clears it.
			out_valid_q <= ((state_q == ST_DONE) && out_free) ||
				(out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (score_acc) begin
						run_q <= run_new;
						if (run_ok && (tf_new != '0)) begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_DIV1S;
				ST_DIV1S: state_q <= (d_q == '0) ? ST_XS : ST_DIV1;
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_XS;
					end
				end
				ST_XS:    state_q <= ST_X2;
				ST_X2:    state_q <= ST_DIV2S;
				ST_DIV2S: state_q <= (den2_q == '0) ? ST_SC1 : ST_DIV2;
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_SC1;
					end
				end
				ST_SC1:   state_q <= ST_SC2;
				ST_SC2:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded according to the sequencer state.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				doc_q <= run_new[15:0];
				tf_q  <= tf_new;
			end
			ST_MUL1: begin
				pa_q  <= 52'(tf_q[19:0]) * 52'(m_eff);
				pd1_q <= 49'(one_minus_b) * 49'(m_eff);
				pd2_q <= 49'(b_eff) * 49'(len);
			end
			ST_MUL2: begin
				pb_q <= 52'(tf_q[39:20]) * 52'(m_eff);
				d_q  <= 50'(pd1_q) + 50'(pd2_q);
			end
			ST_DIV1S: begin
				cp_q <= CPrimeCap;
			end
			ST_DIV1: begin
				if (div_done) begin
					cp_q <= (div_quo[DivNumW-1:48] != '0) ? CPrimeCap : div_quo[47:0];
				end
			end
			ST_XS: begin
				x_q    <= x_new;
				den2_q <= 50'(k1_q) + 50'(x_new);
				pxl_q  <= 50'(k1p1) * 50'(x_new[24:0]);
			end
			ST_X2: begin
				pxh_q <= 49'(k1p1) * 49'(x_q[48:25]);
			end
			ST_DIV2S: begin
				fp_q <= k1p1;
			end
			ST_DIV2: begin
				if (div_done) begin
					fp_q <= div_quo[24:0];
				end
			end
			ST_SC1: begin
				s1_q <= sc1_prod[48:16];
			end
			ST_SC2: begin
				score_q <= (sc2_prod[56:48] != '0) ? '1 : sc2_prod[47:16];
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.doc_number <= doc_q;
					out_q.score      <= score_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== hdl/bm25ps_len_ram.sv =====
`timescale 1ns / 1ps
// Document length table: one write port and one registered read port.
// Depends on bm25ps_pkg only through the top level's parameters.
module bm25ps_len_ram #(
	parameter int Depth = 65536,
	parameter int Width = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== hdl/bm25ps_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on bm25ps_pkg for its widths.
module bm25ps_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bm25ps_pkg::DivNumW-1:0] num,
	input  logic [bm25ps_pkg::DivDenW-1:0] den,
	output logic                       done,
	output logic [bm25ps_pkg::DivNumW-1:0] quo
);
	import bm25ps_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivNumW-1:0] nq_q;
	logic [DivDenW-1:0] rem_q;
	logic [DivDenW-1:0] den_q;
	logic [DivDenW:0]   trial;
	logic               ge;
	logic [DivDenW-1:0] rem_next;

	// One trial subtraction: the numerator bit shifts into the remainder.
	always_comb begin
		trial    = {rem_q, nq_q[DivNumW-1]};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
	end

	// Control: busy for one cycle per numerator bit, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivNumW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Numerator and quotient share one shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DivNumW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign quo  = nq_q;
endmodule
